// ===== hw/rtl/mdbl_pkg.sv =====
// ----------------------------------------------------------------------------
// mdbl_pkg: shared types and constants of the bus master link
// Operation, result kind and register index codes, the result record and
// the reset values of the configuration registers.
// ----------------------------------------------------------------------------
package mdbl_pkg;

  // Request operation codes
  typedef enum logic [2:0] {
    OP_CMD  = 3'd0,
    OP_DATA = 3'd1,
    OP_ACK  = 3'd2,
    OP_RET  = 3'd3,
    OP_NAK  = 3'd4,
    OP_RX   = 3'd5,
    OP_TICK = 3'd6
  } op_t;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_TX      = 2'd0,
    KIND_RX      = 2'd1,
    KIND_TIMEOUT = 2'd2
  } kind_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_TIMEOUT = 2'd0,
    REG_ACK     = 2'd1,
    REG_RET     = 2'd2,
    REG_NAK     = 2'd3
  } reg_idx_t;

  localparam int REG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  // Reset values of the configuration registers
  localparam logic [15:0] TIMEOUT_RST = 16'd100;
  localparam logic [7:0]  ACK_RST     = 8'h00;
  localparam logic [7:0]  RET_RST     = 8'hAA;
  localparam logic [7:0]  NAK_RST     = 8'hFF;

  // Mode bit of a bus word, and the saturation value of the ms counter
  localparam int          MODE_BIT    = 8;
  localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

  // Result queue geometry
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = 2;
  localparam int CNT_W      = 3;

  // One result record
  typedef struct packed {
    kind_t      kind;
    logic [8:0] tx_word;
    logic [7:0] rx_byte;
    logic [5:0] rx_count;
    logic       response_end;
    logic       last;
  } res_t;

endpackage

// ===== hw/rtl/mdbl_in_if.sv =====
// ----------------------------------------------------------------------------
// mdbl_in_if: request channel of the bus master link
// Valid/ready channel carrying one link operation and its operands.
// ----------------------------------------------------------------------------
interface mdbl_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic [7:0] peripheral_address;
  logic [7:0] command_code;
  logic [7:0] data_byte;
  logic       last_byte;
  logic [8:0] received_word;

  modport source (
    output valid, operation, peripheral_address, command_code, data_byte,
           last_byte, received_word,
    input  ready
  );

  modport sink (
    input  valid, operation, peripheral_address, command_code, data_byte,
           last_byte, received_word,
    output ready
  );
endinterface

// ===== hw/rtl/mdbl_out_if.sv =====
// ----------------------------------------------------------------------------
// mdbl_out_if: result channel of the bus master link
// Valid/ready channel carrying transmit words, received bytes and timeouts.
// ----------------------------------------------------------------------------
interface mdbl_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [8:0] tx_word;
  logic [7:0] rx_byte;
  logic [5:0] rx_count;
  logic       response_end;
  logic       last;

  modport source (
    output valid, kind, tx_word, rx_byte, rx_count, response_end, last,
    input  ready
  );

  modport sink (
    input  valid, kind, tx_word, rx_byte, rx_count, response_end, last,
    output ready
  );
endinterface

// ===== hw/rtl/mdbl_cfg_if.sv =====
// ----------------------------------------------------------------------------
// mdbl_cfg_if: configuration write channel of the bus master link
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface mdbl_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  reg_index;
  logic [15:0] wr_data;

  modport source (
    output valid, reg_index, wr_data,
    input  ready
  );

  modport sink (
    input  valid, reg_index, wr_data,
    output ready
  );
endinterface

// ===== hw/rtl/mdb_bus_master_link.sv =====
// ----------------------------------------------------------------------------
// mdb_bus_master_link: master side of a 9-bit multi-drop vending bus link
// Encodes outgoing commands with checksum, tracks the response and its
// millisecond timeout, and reports each word or event as a result.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch   requests: command, data byte, ack, retransmit, nak, received
//           word, millisecond tick. A request is taken when valid and ready.
//   out_ch  results: transmit word, received byte or response timeout; the
//           final result of a request carries last.
//   cfg_ch  register writes (timeout, ack, retransmit and nak codes); ready
//           whenever out of reset, to be written only while the link is idle.
//   Each request is decoded in the cycle it is taken; its results (none, one
//   or two) go to a four-entry result queue, the first showing on out_ch in
//   the next cycle if nothing was queued. One request per cycle is taken while
//   the queue holds at most two results, so the rate is one request per
//   cycle when each gives one result and the receiver takes one a cycle;
//   requests that give two results are drained at one result per cycle.
//   When the receiver stalls, the queue fills and in_ch.ready drops.
//   Synchronous reset empties the queue, clears the link state and loads
//   the register defaults; in_ch.ready and cfg_ch.ready stay low while reset
//   is held, and requests may be sent in the cycle after reset.
// ----------------------------------------------------------------------------
module mdb_bus_master_link #(
  parameter int MAX_DATA_BYTES     = 34,
  parameter int MAX_RESPONSE_BYTES = 36
) (
  input  logic              clk,
  input  logic              rst_n,
  mdbl_in_if.sink           in_ch,
  mdbl_out_if.source        out_ch,
  mdbl_cfg_if.sink          cfg_ch
);

  localparam logic [5:0] MAX_DATA_C = 6'(MAX_DATA_BYTES);
  localparam logic [5:0] MAX_RESP_C = 6'(MAX_RESPONSE_BYTES);

  // Configuration registers
  logic [15:0] timeout_ms_r;
  logic [7:0]  ack_code_r;
  logic [7:0]  ret_code_r;
  logic [7:0]  nak_code_r;

  // Link state
  logic [7:0]  checksum_r, checksum_nxt;
  logic [5:0]  data_cnt_r, data_cnt_nxt;
  logic        awaiting_r, awaiting_nxt;
  logic [15:0] elapsed_r, elapsed_nxt;
  logic [5:0]  resp_cnt_r, resp_cnt_nxt;
  logic        resp_done_r, resp_done_nxt;

  // Result queue
  mdbl_pkg::res_t                    fifo_r [mdbl_pkg::FIFO_DEPTH];
  logic [mdbl_pkg::PTR_W-1:0]        wr_ptr_r, rd_ptr_r, wr_ptr_p1;
  logic [mdbl_pkg::CNT_W-1:0]        cnt_r, cnt_nxt;

  // Per-request decode
  mdbl_pkg::res_t res_a, res_b;
  logic [1:0]     n_res;
  logic           in_acc, out_acc;
  logic [7:0]     cmd_byte;
  logic [7:0]     sum_upd;
  logic           send_data;
  logic [5:0]     resp_cnt_inc;
  logic           resp_end;
  logic [15:0]    elapsed_inc;

  assign in_ch.ready  = rst_n & (cnt_r <= mdbl_pkg::CNT_W'(2));
  assign cfg_ch.ready = rst_n;
  assign in_acc       = in_ch.valid & in_ch.ready;
  assign out_acc      = out_ch.valid & out_ch.ready;

  assign cmd_byte     = in_ch.peripheral_address | in_ch.command_code;
  assign send_data    = (data_cnt_r < MAX_DATA_C);
  assign sum_upd      = send_data ? (checksum_r + in_ch.data_byte) : checksum_r;
  assign resp_cnt_inc = resp_cnt_r + 6'd1;
  assign resp_end     = in_ch.received_word[mdbl_pkg::MODE_BIT] |
                        (resp_cnt_inc >= MAX_RESP_C);
  assign elapsed_inc  = (elapsed_r != mdbl_pkg::ELAPSED_MAX) ?
                        (elapsed_r + 16'd1) : elapsed_r;

  // Decode the request into state updates and up to two results
  always_comb begin
    checksum_nxt  = checksum_r;
    data_cnt_nxt  = data_cnt_r;
    awaiting_nxt  = awaiting_r;
    elapsed_nxt   = elapsed_r;
    resp_cnt_nxt  = resp_cnt_r;
    resp_done_nxt = resp_done_r;
    res_a         = '0;
    res_b         = '0;
    n_res         = 2'd0;

    unique case (mdbl_pkg::op_t'(in_ch.operation))
      mdbl_pkg::OP_CMD: begin
        res_a.kind    = mdbl_pkg::KIND_TX;
        res_a.tx_word = {1'b1, cmd_byte};
        checksum_nxt  = cmd_byte;
        data_cnt_nxt  = 6'd0;
        n_res         = 2'd1;
        if (in_ch.last_byte) begin
          res_b.kind    = mdbl_pkg::KIND_TX;
          res_b.tx_word = {1'b0, cmd_byte};
          n_res         = 2'd2;
        end
      end
      mdbl_pkg::OP_DATA: begin
        checksum_nxt = sum_upd;
        if (send_data) begin
          data_cnt_nxt = data_cnt_r + 6'd1;
          res_a.kind    = mdbl_pkg::KIND_TX;
          res_a.tx_word = {1'b0, in_ch.data_byte};
          if (in_ch.last_byte) begin
            res_b.kind    = mdbl_pkg::KIND_TX;
            res_b.tx_word = {1'b0, sum_upd};
            n_res         = 2'd2;
          end else begin
            n_res = 2'd1;
          end
        end else if (in_ch.last_byte) begin
          res_a.kind    = mdbl_pkg::KIND_TX;
          res_a.tx_word = {1'b0, sum_upd};
          n_res         = 2'd1;
        end
      end
      mdbl_pkg::OP_ACK: begin
        res_a.kind    = mdbl_pkg::KIND_TX;
        res_a.tx_word = {1'b0, ack_code_r};
        n_res         = 2'd1;
      end
      mdbl_pkg::OP_RET: begin
        res_a.kind    = mdbl_pkg::KIND_TX;
        res_a.tx_word = {1'b0, ret_code_r};
        n_res         = 2'd1;
      end
      mdbl_pkg::OP_NAK: begin
        res_a.kind    = mdbl_pkg::KIND_TX;
        res_a.tx_word = {1'b0, nak_code_r};
        n_res         = 2'd1;
      end
      mdbl_pkg::OP_RX: begin
        if (!resp_done_r) begin
          resp_cnt_nxt       = resp_cnt_inc;
          resp_done_nxt      = resp_end;
          awaiting_nxt       = 1'b0;
          res_a.kind         = mdbl_pkg::KIND_RX;
          res_a.rx_byte      = in_ch.received_word[7:0];
          res_a.rx_count     = resp_cnt_inc;
          res_a.response_end = resp_end;
          n_res              = 2'd1;
        end
      end
      mdbl_pkg::OP_TICK: begin
        if (awaiting_r) begin
          elapsed_nxt = elapsed_inc;
          if ((elapsed_inc > timeout_ms_r) && (resp_cnt_r == 6'd0)) begin
            awaiting_nxt   = 1'b0;
            res_a.kind     = mdbl_pkg::KIND_TIMEOUT;
            res_a.rx_count = resp_cnt_r;
            n_res          = 2'd1;
          end
        end
      end
      default: begin
        n_res = 2'd0;
      end
    endcase

    // Message end: arm the response wait
    if (in_ch.last_byte && ((mdbl_pkg::op_t'(in_ch.operation) == mdbl_pkg::OP_CMD) ||
                            (mdbl_pkg::op_t'(in_ch.operation) == mdbl_pkg::OP_DATA))) begin
      awaiting_nxt  = 1'b1;
      elapsed_nxt   = 16'd0;
      resp_cnt_nxt  = 6'd0;
      resp_done_nxt = 1'b0;
    end

    // Mark the final result of the request
    res_a.last = (n_res == 2'd1);
    res_b.last = 1'b1;
  end

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_ms_r <= mdbl_pkg::TIMEOUT_RST;
      ack_code_r   <= mdbl_pkg::ACK_RST;
      ret_code_r   <= mdbl_pkg::RET_RST;
      nak_code_r   <= mdbl_pkg::NAK_RST;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (mdbl_pkg::reg_idx_t'(cfg_ch.reg_index))
        mdbl_pkg::REG_TIMEOUT: timeout_ms_r <= cfg_ch.wr_data;
        mdbl_pkg::REG_ACK:     ack_code_r   <= cfg_ch.wr_data[7:0];
        mdbl_pkg::REG_RET:     ret_code_r   <= cfg_ch.wr_data[7:0];
        mdbl_pkg::REG_NAK:     nak_code_r   <= cfg_ch.wr_data[7:0];
        default:               timeout_ms_r <= timeout_ms_r;
      endcase
    end
  end

  // Advance link state on each taken request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      checksum_r  <= 8'd0;
      data_cnt_r  <= 6'd0;
      awaiting_r  <= 1'b0;
      elapsed_r   <= 16'd0;
      resp_cnt_r  <= 6'd0;
      resp_done_r <= 1'b0;
    end else if (in_acc) begin
      checksum_r  <= checksum_nxt;
      data_cnt_r  <= data_cnt_nxt;
      awaiting_r  <= awaiting_nxt;
      elapsed_r   <= elapsed_nxt;
      resp_cnt_r  <= resp_cnt_nxt;
      resp_done_r <= resp_done_nxt;
    end
  end

  // Result queue: push up to two, pop one
  assign wr_ptr_p1 = wr_ptr_r + mdbl_pkg::PTR_W'(1);

  always_comb begin
    cnt_nxt = cnt_r;
    if (in_acc) begin
      cnt_nxt = cnt_nxt + mdbl_pkg::CNT_W'(n_res);
    end
    if (out_acc) begin
      cnt_nxt = cnt_nxt - mdbl_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && (n_res != 2'd0)) begin
      fifo_r[wr_ptr_r] <= res_a;
    end
    if (in_acc && (n_res == 2'd2)) begin
      fifo_r[wr_ptr_p1] <= res_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (in_acc) begin
        wr_ptr_r <= wr_ptr_r + mdbl_pkg::PTR_W'(n_res);
      end
      if (out_acc) begin
        rd_ptr_r <= rd_ptr_r + mdbl_pkg::PTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  // Drive the result channel from the queue head
  assign out_ch.valid        = (cnt_r != '0);
  assign out_ch.kind         = fifo_r[rd_ptr_r].kind;
  assign out_ch.tx_word      = fifo_r[rd_ptr_r].tx_word;
  assign out_ch.rx_byte      = fifo_r[rd_ptr_r].rx_byte;
  assign out_ch.rx_count     = fifo_r[rd_ptr_r].rx_count;
  assign out_ch.response_end = fifo_r[rd_ptr_r].response_end;
  assign out_ch.last         = fifo_r[rd_ptr_r].last;

`ifndef SYNTHESIS
  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= mdbl_pkg::CNT_W'(mdbl_pkg::FIFO_DEPTH))
    else $error("result queue overflow");

  a_done_not_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    resp_done_r |-> !awaiting_r)
    else $error("response ended while still waiting");

  a_data_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    data_cnt_r <= MAX_DATA_C)
    else $error("data byte count past limit");

  a_resp_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    resp_cnt_r <= MAX_RESP_C)
    else $error("response count past limit");
`endif

endmodule
